FILE: rtl/cmrp_pkg.sv
// shared types, widths and status codes of the coap response header parser
package cmrp_pkg;

   localparam int MAX_PACKET_BYTES_DEF = 1024;

   localparam int STATUS_W = 3;
   localparam int CODE_W   = 8;
   localparam int MSG_ID_W = 16;
   localparam int OFFSET_W = 11;
   localparam int SKIP_W   = 4;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_SHORT     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_CODE  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NO_MARKER = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LONG  = 3'd4;

   localparam logic [7:0] LEN_NIBBLE_MASK = 8'h0F;
   localparam logic [7:0] CLASS_MASK      = 8'hE0;
   localparam logic [7:0] CLASS_SUCCESS   = 8'h40;
   localparam logic [7:0] PAYLOAD_MARKER  = 8'hFF;
   localparam int         HEADER_BYTES    = 4;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       last_byte;
   } item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CODE_W-1:0]   reply_code;
      logic [MSG_ID_W-1:0] msg_ident;
      logic [OFFSET_W-1:0] payload_offset;
   } result_type;

endpackage

FILE: rtl/cmrp_in.sv
// input register stage holding one received byte
module cmrp_in (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_packet_byte,
   input  logic              req_last_byte,
   output logic              item_valid,
   output cmrp_pkg::item_type item,
   input  logic              item_take
);
   import cmrp_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   assign req_ready = !valid_ff || item_take;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (item_take) begin
         valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         valid_in            = 1'b1;
         item_in.packet_byte = req_packet_byte;
         item_in.last_byte   = req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
endmodule

FILE: rtl/cmrp_parse.sv
// header, token and option scan state with the per-datagram result logic
module cmrp_parse #(
   parameter int MAX_PACKET_BYTES = cmrp_pkg::MAX_PACKET_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  cmrp_pkg::item_type   item,
   output logic                 item_take,
   input  logic                 out_free,
   output logic                 res_valid,
   output cmrp_pkg::result_type res
);
   import cmrp_pkg::*;

   localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_PACKET_BYTES);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_TOKEN,
      PH_SEEK,
      PH_OPTSKIP,
      PH_DONE
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [SKIP_W-1:0]  skip_ff, skip_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic [MSG_ID_W-1:0] id_ff, id_in;
   logic [POS_W-1:0]   mark_ff, mark_in;
   logic               found_ff, found_in;
   logic               over_ff, over_in;
   logic [SKIP_W-1:0]  skip_dec;
   logic [SKIP_W-1:0]  nibble;
   logic               fire;

   // a last byte needs room in the result register, other bytes never wait
   assign fire      = item_valid && (!item.last_byte || out_free);
   assign item_take = fire;
   assign nibble    = SKIP_W'(item.packet_byte & LEN_NIBBLE_MASK);
   assign skip_dec  = (skip_ff != '0) ? skip_ff - SKIP_W'(1) : skip_ff;

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      skip_in  = skip_ff;
      code_in  = code_ff;
      id_in    = id_ff;
      mark_in  = mark_ff;
      found_in = found_ff;
      over_in  = over_ff;

      if (over_ff || pos_ff >= POS_LIMIT) begin
         over_in = 1'b1;
      end else begin
         pos_in = pos_ff + POS_W'(1);
         case (phase_ff)
            PH_HEADER: begin
               if (pos_ff == POS_W'(0)) begin
                  skip_in = nibble;
               end else if (pos_ff == POS_W'(1)) begin
                  code_in = item.packet_byte;
               end else if (pos_ff == POS_W'(2)) begin
                  id_in = {item.packet_byte, 8'h00};
               end else begin
                  id_in    = {id_ff[MSG_ID_W-1:8], item.packet_byte};
                  phase_in = (skip_ff != '0) ? PH_TOKEN : PH_SEEK;
               end
            end
            PH_TOKEN, PH_OPTSKIP: begin
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  phase_in = PH_SEEK;
               end
            end
            PH_SEEK: begin
               if (item.packet_byte == PAYLOAD_MARKER) begin
                  found_in = 1'b1;
                  mark_in  = pos_ff + POS_W'(1);
                  phase_in = PH_DONE;
               end else begin
                  skip_in = nibble;
                  if (nibble != '0) begin
                     phase_in = PH_OPTSKIP;
                  end
               end
            end
            default: begin
               // payload bytes after the marker are ignored
            end
         endcase
      end

      res = '0;
      if (over_in) begin
         res.status = STATUS_TOO_LONG;
      end else if (pos_in < POS_W'(HEADER_BYTES)) begin
         res.status = STATUS_SHORT;
      end else begin
         res.reply_code = code_in;
         res.msg_ident  = id_in;
         if ((code_in & CLASS_MASK) != CLASS_SUCCESS) begin
            res.status = STATUS_BAD_CODE;
         end else if (!found_in) begin
            res.status = STATUS_NO_MARKER;
         end else begin
            res.status         = STATUS_OK;
            res.payload_offset = OFFSET_W'(mark_in);
         end
      end
   end

   assign res_valid = fire && item.last_byte;

   always_ff @(posedge clock) begin
      if (reset || res_valid) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= '0;
         skip_ff  <= '0;
         code_ff  <= '0;
         id_ff    <= '0;
         mark_ff  <= '0;
         found_ff <= 1'b0;
         over_ff  <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         skip_ff  <= skip_in;
         code_ff  <= code_in;
         id_ff    <= id_in;
         mark_ff  <= mark_in;
         found_ff <= found_in;
         over_ff  <= over_in;
      end
   end
endmodule

FILE: rtl/cmrp_out.sv
// result register driving the response channel
module cmrp_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_valid,
   input  cmrp_pkg::result_type res,
   output logic                 out_free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [cmrp_pkg::STATUS_W-1:0] rsp_status,
   output logic [cmrp_pkg::CODE_W-1:0]   rsp_reply_code,
   output logic [cmrp_pkg::MSG_ID_W-1:0] rsp_msg_ident,
   output logic [cmrp_pkg::OFFSET_W-1:0] rsp_payload_offset
);
   import cmrp_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (res_valid) begin
         valid_in = 1'b1;
         data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_status         = data_ff.status;
   assign rsp_reply_code     = data_ff.reply_code;
   assign rsp_msg_ident      = data_ff.msg_ident;
   assign rsp_payload_offset = data_ff.payload_offset;
endmodule

FILE: rtl/coap_response_header_parser.sv
// top level of the coap response header parser
// throughput: one datagram byte per cycle while the response side keeps up
// result path: the last byte is registered in the input register, then the
//   parse logic runs from the input register into the result register
// reset: synchronous, clears the parse state and both valid flags
module coap_response_header_parser #(
   parameter int MAX_PACKET_BYTES = cmrp_pkg::MAX_PACKET_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_packet_byte,
   input  logic                              req_last_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cmrp_pkg::STATUS_W-1:0]     rsp_status,
   output logic [cmrp_pkg::CODE_W-1:0]       rsp_reply_code,
   output logic [cmrp_pkg::MSG_ID_W-1:0]     rsp_msg_ident,
   output logic [cmrp_pkg::OFFSET_W-1:0]     rsp_payload_offset
);
   import cmrp_pkg::*;

   logic       item_valid;
   item_type   item;
   logic       item_take;
   logic       out_free;
   logic       res_valid;
   result_type res;

   cmrp_in u_in (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_packet_byte (req_packet_byte),
      .req_last_byte   (req_last_byte),
      .item_valid      (item_valid),
      .item            (item),
      .item_take       (item_take)
   );

   cmrp_parse #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .out_free   (out_free),
      .res_valid  (res_valid),
      .res        (res)
   );

   cmrp_out u_out (
      .clock              (clock),
      .reset              (reset),
      .res_valid          (res_valid),
      .res                (res),
      .out_free           (out_free),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_reply_code     (rsp_reply_code),
      .rsp_msg_ident      (rsp_msg_ident),
      .rsp_payload_offset (rsp_payload_offset)
   );
endmodule

FILE: rtl/cmrp_checker.sv
// port-level checks of the coap response header parser and their bind
module cmrp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [cmrp_pkg::STATUS_W-1:0]     rsp_status,
   input logic [cmrp_pkg::CODE_W-1:0]       rsp_reply_code,
   input logic [cmrp_pkg::MSG_ID_W-1:0]     rsp_msg_ident,
   input logic [cmrp_pkg::OFFSET_W-1:0]     rsp_payload_offset
);
   import cmrp_pkg::*;

   // a stalled result holds its valid, status, message id and payload offset
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_msg_ident) && $stable(rsp_payload_offset))
      else $error("stalled result changed");

   // with the result register empty nothing can hold the input back
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with an empty result register");

   a_fail_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_payload_offset == '0)
      else $error("payload offset set on a failed datagram");

   a_short_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_SHORT || rsp_status == STATUS_TOO_LONG)
         |-> rsp_reply_code == '0 && rsp_msg_ident == '0)
      else $error("header fields set on a short or too long datagram");

   a_ok_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK
         |-> (rsp_reply_code & CLASS_MASK) == CLASS_SUCCESS)
      else $error("ok status with a code outside class 2");
endmodule

bind coap_response_header_parser cmrp_checker u_cmrp_checker (.*);

FILE: test/coap_response_header_parser_tb.sv
// self-checking testbench for the coap response header parser
module coap_response_header_parser_tb;
   import cmrp_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int MAX_BYTES    = MAX_PACKET_BYTES_DEF;
   localparam int DRAIN_CYCLES = 4;

   typedef enum logic [2:0] {
      SCAN_HEADER, SCAN_TOKEN, SCAN_SEEK, SCAN_OPT_VALUE, SCAN_PAYLOAD
   } scan_state_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [7:0]          req_packet_byte = '0;
   logic                req_last_byte = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [CODE_W-1:0]   rsp_reply_code;
   logic [MSG_ID_W-1:0] rsp_msg_ident;
   logic [OFFSET_W-1:0] rsp_payload_offset;

   // header parse state of the predictor
   logic [10:0]    byte_count;
   scan_state_type scan;
   logic [7:0]     skip_left;
   logic [7:0]     code_q;
   logic [15:0]    ident_q;
   logic [10:0]    marker_at;
   logic           marker_seen;
   logic           too_long;

   result_type  expected_responses[$];
   logic [7:0]  datagram[$];
   int          mismatches = 0;
   int          bytes_sent = 0;
   int          burst_left = 0;

   coap_response_header_parser #(
      .MAX_PACKET_BYTES(MAX_BYTES)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_packet_byte(req_packet_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_reply_code(rsp_reply_code),
      .rsp_msg_ident(rsp_msg_ident),
      .rsp_payload_offset(rsp_payload_offset)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(CLOCK_PERIOD * 400000);
      $display("Simulation FAILED");
      $finish;
   end

   task automatic clear_parse_state();
      byte_count  = '0;
      scan        = SCAN_HEADER;
      skip_left   = '0;
      code_q      = '0;
      ident_q     = '0;
      marker_at   = '0;
      marker_seen = 1'b0;
      too_long    = 1'b0;
   endtask

   // advance the header parse by one byte, queue a response on the last byte
   task automatic parse_datagram_byte(input logic [7:0] b, input logic last);
      result_type r;
      if (too_long || byte_count >= MAX_BYTES) begin
         too_long = 1'b1;
      end else begin
         case (scan)
            SCAN_HEADER: begin
               case (byte_count)
                  11'd0: skip_left = b & LEN_NIBBLE_MASK;
                  11'd1: code_q = b;
                  11'd2: ident_q = {b, 8'h00};
                  default: begin
                     ident_q[7:0] = b;
                     scan = (skip_left != 0) ? SCAN_TOKEN : SCAN_SEEK;
                  end
               endcase
            end
            SCAN_TOKEN, SCAN_OPT_VALUE: begin
               if (skip_left != 0) skip_left = skip_left - 1'b1;
               if (skip_left == 0) scan = SCAN_SEEK;
            end
            SCAN_SEEK: begin
               if (b == PAYLOAD_MARKER) begin
                  marker_seen = 1'b1;
                  marker_at   = byte_count + 1'b1;
                  scan        = SCAN_PAYLOAD;
               end else begin
                  skip_left = b & LEN_NIBBLE_MASK;
                  if (skip_left != 0) scan = SCAN_OPT_VALUE;
               end
            end
            default: ;
         endcase
         byte_count = byte_count + 1'b1;
      end
      if (last) begin
         r = '0;
         if (too_long) begin
            r.status = STATUS_TOO_LONG;
         end else if (byte_count < HEADER_BYTES) begin
            r.status = STATUS_SHORT;
         end else begin
            r.reply_code = code_q;
            r.msg_ident  = ident_q;
            if ((code_q & CLASS_MASK) != CLASS_SUCCESS) begin
               r.status = STATUS_BAD_CODE;
            end else if (!marker_seen) begin
               r.status = STATUS_NO_MARKER;
            end else begin
               r.status         = STATUS_OK;
               r.payload_offset = marker_at;
            end
         end
         expected_responses.push_back(r);
         clear_parse_state();
      end
   endtask

   // one byte transfer, with random gaps between bursts
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_packet_byte <= b;
      req_last_byte   <= last;
      @(negedge clock);
      while (req_ready !== 1'b1) @(negedge clock);
      @(posedge clock);
      bytes_sent++;
      parse_datagram_byte(b, last);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_datagram(input int pause_at);
      for (int i = 0; i < datagram.size(); i++) begin
         if (i == pause_at) wait_drained();
         send_byte(datagram[i], i == datagram.size() - 1);
      end
   endtask

   task automatic add_random_bytes(input int n);
      repeat (n) datagram.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic build_response(input logic [7:0] code, input logic [15:0] ident,
                                 input int tkl, input int n_opts, input bit with_marker,
                                 input int payload_len);
      logic [7:0] first;
      logic [7:0] opt;
      first      = 8'($urandom_range(0, 255));
      first[3:0] = 4'(tkl);
      datagram.delete();
      datagram.push_back(first);
      datagram.push_back(code);
      datagram.push_back(ident[15:8]);
      datagram.push_back(ident[7:0]);
      add_random_bytes(tkl);
      repeat (n_opts) begin
         do opt = 8'($urandom_range(0, 255)); while (opt == PAYLOAD_MARKER);
         datagram.push_back(opt);
         add_random_bytes(opt & LEN_NIBBLE_MASK);
      end
      if (with_marker) datagram.push_back(PAYLOAD_MARKER);
      add_random_bytes(payload_len);
   endtask

   function automatic logic [7:0] success_code();
      return CLASS_SUCCESS | (8'($urandom_range(0, 255)) & ~CLASS_MASK);
   endfunction

   function automatic logic [7:0] failure_code();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while ((c & CLASS_MASK) == CLASS_SUCCESS);
      return c;
   endfunction

   task automatic test_short_frames();
      datagram = '{8'h00};
      send_datagram(-1);
      datagram = '{8'hFF, 8'hFF};
      send_datagram(-1);
      datagram = '{8'h40, CLASS_SUCCESS, 8'h12};
      send_datagram(-1);
   endtask

   task automatic test_header_extremes();
      build_response(CLASS_SUCCESS, 16'h0000, 0, 0, 1, 0);
      send_datagram(-1);
      build_response(8'h5F, 16'hFFFF, 15, 3, 1, 4);
      send_datagram(-1);
      build_response(8'h45, 16'hA55A, 8, 2, 1, 2);
      send_datagram(-1);
   endtask

   task automatic test_bad_codes();
      logic [7:0] codes[$];
      codes = '{8'h00, 8'hFF, 8'h3F, 8'h60, 8'h80, 8'hA0, 8'hC0, 8'hE0};
      foreach (codes[i]) begin
         build_response(codes[i], 16'($urandom_range(0, 65535)), 1, 1, 1, 2);
         send_datagram(-1);
      end
      // bad code outranks a missing marker
      build_response(8'h84, 16'h0102, 0, 2, 0, 0);
      send_datagram(-1);
   endtask

   task automatic test_marker_rules();
      // bare four byte header, no marker
      build_response(CLASS_SUCCESS, 16'h4000, 0, 0, 0, 0);
      send_datagram(-1);
      build_response(8'h44, 16'h0001, 3, 3, 0, 0);
      send_datagram(-1);
      // token running past the end
      build_response(8'h41, 16'h0203, 8, 0, 1, 0);
      while (datagram.size() > 7) void'(datagram.pop_back());
      send_datagram(-1);
      // option value running past the end
      datagram = '{8'h50, 8'h45, 8'h33, 8'h44, 8'hBC, 8'h01, 8'h02};
      send_datagram(-1);
      // 0xff inside token and option value is not a marker, payload may hold 0xff
      datagram = '{8'h52, 8'h44, 8'h10, 8'h20, 8'hFF, 8'hFF, 8'h21, 8'hFF,
                   8'h00, PAYLOAD_MARKER, 8'hFF, 8'h00};
      send_datagram(-1);
      // marker on the final byte
      build_response(8'h43, 16'h7F7F, 2, 1, 1, 0);
      send_datagram(-1);
   endtask

   task automatic test_length_bound();
      // marker as byte 1023 gives the largest offset
      build_response(8'h45, 16'hBEEF, 0, 0, 0, 0);
      while (datagram.size() < MAX_BYTES - 1) begin
         datagram.push_back(8'($urandom_range(0, 15) << 4));
      end
      datagram.push_back(PAYLOAD_MARKER);
      send_datagram(-1);
      // one byte over the bound
      datagram.push_back(8'($urandom_range(0, 255)));
      send_datagram(-1);
   endtask

   task automatic test_drain_mid_frame();
      build_response(success_code(), 16'($urandom_range(0, 65535)), 2, 2, 1, 3);
      send_datagram(6);
   endtask

   task automatic test_random_traffic();
      int frames;
      int kind;
      int first_byte;
      int keep;
      int pause_at;
      frames     = 0;
      first_byte = bytes_sent;
      while (bytes_sent - first_byte < 700 || frames < 60) begin
         kind = $urandom_range(0, 9);
         if (kind <= 5 || kind == 7) begin
            build_response(success_code(), 16'($urandom_range(0, 65535)),
                           ($urandom_range(0, 7) == 0) ? $urandom_range(9, 15)
                                                       : $urandom_range(0, 8),
                           $urandom_range(0, 3), (kind == 7) || ($urandom_range(0, 7) != 0),
                           $urandom_range(0, 8));
            if (kind == 7 && datagram.size() > 4) begin
               keep = $urandom_range(4, datagram.size() - 1);
               while (datagram.size() > keep) void'(datagram.pop_back());
            end
         end else if (kind == 6) begin
            build_response(failure_code(), 16'($urandom_range(0, 65535)),
                           $urandom_range(0, 8), $urandom_range(0, 3),
                           1'($urandom_range(0, 1)), $urandom_range(0, 4));
         end else begin
            datagram.delete();
            add_random_bytes((kind == 8) ? $urandom_range(1, 24) : $urandom_range(1, 3));
         end
         pause_at = (frames % 16 == 15) ? $urandom_range(0, datagram.size() - 1) : -1;
         send_datagram(pause_at);
         frames++;
      end
   endtask

   // receiver stall pattern: modes of random length
   initial begin
      int mode;
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(20, 200)) begin
            @(posedge clock);
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 7) != 0);
               default: rsp_ready <= ($urandom_range(0, 15) == 0);
            endcase
         end
      end
   end

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // response side sampled mid-cycle, the transfer lands on the next edge
   initial begin
      result_type want;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
            if (expected_responses.size() == 0) begin
               $error("unexpected response: status %0d", rsp_status);
               mismatches++;
            end else begin
               want = expected_responses.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("reply_code", want.reply_code, rsp_reply_code);
               check_field("msg_ident", want.msg_ident, rsp_msg_ident);
               check_field("payload_offset", want.payload_offset, rsp_payload_offset);
            end
         end
      end
   end

   initial begin
      clear_parse_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_short_frames();
      test_header_extremes();
      test_bad_codes();
      test_marker_rules();
      test_drain_mid_frame();
      test_length_bound();
      test_random_traffic();
      wait_drained();
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
